// ===== rtl/ale_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

  localparam int MAX_ROWS = 10;
  localparam int ROW_W = 4;
  localparam int FRAC_BITS = 24;

  typedef logic signed [31:0] q24_t;

  // one position of the two row stores
  typedef struct packed {
    q24_t prev;
    q24_t prev2;
  } ale_entry_t;

  localparam q24_t ONE_Q24 = 32'sh0100_0000;

  // recursion factors in Q8.24, rounded to nearest
  // A[n] = (2n-1)/n, B[n] = (n-1)/n
  localparam q24_t A_ROM [MAX_ROWS] = '{
    32'sd0, 32'sd16777216, 32'sd25165824, 32'sd27962027, 32'sd29360128,
    32'sd30198989, 32'sd30758229, 32'sd31157687, 32'sd31457280, 32'sd31690297
  };
  localparam q24_t B_ROM [MAX_ROWS] = '{
    32'sd0, 32'sd0, 32'sd8388608, 32'sd11184811, 32'sd12582912,
    32'sd13421773, 32'sd13981013, 32'sd14380471, 32'sd14680064, 32'sd14913081
  };
  // C[l] = (l+1)/(2l+3), D[l] = l/(2l-1), D[0] = 0; C[9] and D[9] are 0
  localparam q24_t C_ROM [MAX_ROWS] = '{
    32'sd5592405, 32'sd6710886, 32'sd7190235, 32'sd7456540, 32'sd7626007,
    32'sd7743330, 32'sd7829367, 32'sd7895160, 32'sd7947102, 32'sd0
  };
  localparam q24_t D_ROM [MAX_ROWS] = '{
    32'sd0, 32'sd16777216, 32'sd11184811, 32'sd10066330, 32'sd9586981,
    32'sd9320676, 32'sd9151209, 32'sd9033886, 32'sd8947849, 32'sd0
  };

  // clamp to the Q8.24 range
  function automatic q24_t sat32(input logic signed [42:0] x);
    q24_t r;
    if (x > 43'sd2147483647) r = 32'sh7fff_ffff;
    else if (x < -43'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ale_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ale_cell
  import ale_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       adv,
  input  wire ale_entry_t din,
  output ale_entry_t      dout
);

  // take the neighbor's entry on every advance
  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ale_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ale_mul
  import ale_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [33:0] op_a,
  input  wire q24_t               op_b,
  output logic signed [41:0]      rnd,
  output q24_t                    rnd_sat
);

  logic signed [65:0] prod;
  logic signed [65:0] biased;

  // registered product, rounding happens on the register output
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  assign biased  = prod + 66'sd8388608;
  assign rnd     = biased[65:24];
  assign rnd_sat = sat32(43'(rnd));

endmodule

`default_nettype wire

// ===== rtl/affine_legendre_expansion.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Signals                     | Contents
// in      | in  | s_tvalid s_tready s_tdata   | shift, scale
// out     | out | m_tvalid m_tready m_tdata   | coeff, degree, term_index; m_tlast = last
// cfg     | in  | cfg_valid cfg_ready cfg_data| rows_in_use
// One request at a time, accepted in the idle state. Each coefficient below the diagonal
// takes seven products on the single shared multiplier, each product registered there,
// plus an emit step. A diagonal entry takes one product, and row 0 takes none. Each row
// closes with one fill step per unused position of the cell ring. rst clears control
// and rows_in_use (to 10); the row cells need no reset, as row 0 rewrites both stores.
// A stalled output holds the engine at its emit step; the next request is taken while
// the final item still waits.

module affine_legendre_expansion
  import ale_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // shift [31:0], scale [63:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // coeff [31:0], degree [35:32], term_index [39:36]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT, S_FILL} state_t;

  state_t                state;
  logic [ROW_W-1:0]      rows_in_use;
  logic [ROW_W-1:0]      rows_q;
  logic [ROW_W-1:0]      n;
  logic [ROW_W-1:0]      l;
  logic [2:0]            step;
  q24_t                  shift_q, scale_q, t1, t2, fresh, e1left;
  logic signed [33:0]    acc;
  logic signed [41:0]    v2;
  logic signed [33:0]    op_a;
  q24_t                  op_b;
  logic signed [41:0]    rnd;
  q24_t                  rnd_sat;
  logic                  out_free, adv, diag, row_end;
  q24_t                  adv_val;
  ale_entry_t            cells [MAX_ROWS];
  ale_entry_t            cin   [MAX_ROWS];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign diag      = (l == n);
  assign adv       = (state == S_EMIT && out_free) || (state == S_FILL);
  assign adv_val   = (state == S_EMIT) ? fresh : '0;
  assign row_end   = (l == ROW_W'(MAX_ROWS - 1));

  // ring of row cells: cell 0 holds the current position; row 0 clears the older row
  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    if (k == MAX_ROWS - 1) begin : g_wrap
      assign cin[k] = '{prev: adv_val, prev2: (n == '0) ? '0 : cells[0].prev};
    end else begin : g_link
      assign cin[k] = cells[k+1];
    end
    ale_cell u_cell (.clk(clk), .adv(adv), .din(cin[k]), .dout(cells[k]));
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      3'd0: begin
        op_a = 34'(diag ? e1left : cells[1].prev);
        op_b = scale_q;
      end
      3'd1: begin op_a = 34'(e1left);         op_b = scale_q;  end
      3'd2: begin op_a = 34'(cells[0].prev);  op_b = shift_q;  end
      3'd3: begin op_a = 34'(t1);             op_b = C_ROM[l]; end
      3'd4: begin op_a = 34'(t2);             op_b = D_ROM[l]; end
      3'd5: begin op_a = 34'(cells[0].prev2); op_b = B_ROM[n]; end
      3'd6: begin op_a = acc;                 op_b = A_ROM[n]; end
      default: begin op_a = '0;               op_b = '0;       end
    endcase
  end

  ale_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .rnd(rnd), .rnd_sat(rnd_sat));

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_in_use <= ROW_W'(MAX_ROWS);
      m_tvalid    <= 1'b0;
      n           <= '0;
      l           <= '0;
      step        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) rows_in_use <= cfg_data;
      // the emit step reloads the output register in the same cycle
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            shift_q <= s_tdata[31:0];
            scale_q <= s_tdata[63:32];
            rows_q  <= (rows_in_use > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : rows_in_use;
            n       <= '0;
            l       <= '0;
            step    <= '0;
            e1left  <= '0;
            if (rows_in_use != '0) state <= S_CALC;
          end
        end
        S_CALC: begin
          step <= step + 3'd1;
          if (n == '0) begin
            fresh <= ONE_Q24;
            state <= S_EMIT;
          end else if (diag) begin
            if (step == 3'd1) begin
              fresh <= rnd_sat;
              state <= S_EMIT;
            end
          end else begin
            case (step)
              3'd1: t1 <= rnd_sat;
              3'd2: t2 <= rnd_sat;
              3'd3: acc <= 34'(rnd_sat);
              3'd4, 3'd5: acc <= acc + 34'(rnd_sat);
              3'd6: v2 <= rnd;
              3'd7: begin
                fresh <= sat32(43'(rnd) - 43'(v2));
                state <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid        <= 1'b1;
            m_tdata[31:0]   <= fresh;
            m_tdata[35:32]  <= n;
            m_tdata[39:36]  <= l;
            m_tlast         <= (n == rows_q - ROW_W'(1)) && diag;
            step            <= '0;
            if (!diag) begin
              l      <= l + ROW_W'(1);
              e1left <= cells[0].prev;
              state  <= S_CALC;
            end else if (!row_end) begin
              l      <= l + ROW_W'(1);
              state  <= S_FILL;
            end else if (n == rows_q - ROW_W'(1)) begin
              state <= S_IDLE;
            end else begin
              n      <= n + ROW_W'(1);
              l      <= '0;
              e1left <= '0;
              state  <= S_CALC;
            end
          end
        end
        S_FILL: begin
          if (row_end) begin
            l      <= '0;
            e1left <= '0;
            step   <= '0;
            if (n == rows_q - ROW_W'(1)) begin
              state <= S_IDLE;
            end else begin
              n     <= n + ROW_W'(1);
              state <= S_CALC;
            end
          end else begin
            l <= l + ROW_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks on the sequencer
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (n < rows_q && l < ROW_W'(MAX_ROWS)))
    else $error("row or position out of range");
  a_calc_tri: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> (l <= n))
    else $error("coefficient above the diagonal");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output item changed while stalled");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !out_free) |=> (state == S_EMIT && $stable(l)))
    else $error("emit step left while output stalled");

endmodule

`default_nettype wire

// ===== tb/ale_checker.sv =====
`timescale 1ns / 1ps

module ale_checker
  import ale_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          coeffs_seen
);

  typedef struct {
    logic signed [31:0] coeff;
    logic [3:0] degree;
    logic [3:0] term_index;
    logic last;
  } coeff_item_t;

  coeff_item_t coeff_q[$];
  logic [3:0] row_count;

  // floor of x / 2^24 after adding half an LSB
  function automatic longint rnd24(input longint x);
    return (x + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mulq(input longint x, input longint y);
    return clamp32(rnd24(x * y));
  endfunction

  // Q8.24 constant num/den rounded to nearest
  function automatic longint frac_q24(input longint num, input longint den);
    return ((num <<< 25) + den) / (2 * den);
  endfunction

  function automatic longint entry(input longint r[10], input int idx, input int len);
    if (idx < 0 || idx >= len || idx >= MAX_ROWS) return 0;
    return r[idx];
  endfunction

  // expand one (shift, scale) request into its coefficient triangle
  task automatic expand_request(input logic [63:0] data);
    longint sh, sc, a, b, c, d, inner;
    longint prev[10], prev2[10], fresh[10];
    int rows;
    coeff_item_t it;
    sh = longint'($signed(data[31:0]));
    sc = longint'($signed(data[63:32]));
    rows = (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
    for (int i = 0; i < 10; i++) begin
      prev[i] = 0;
      prev2[i] = 0;
    end
    for (int n = 0; n < rows; n++) begin
      for (int i = 0; i < 10; i++) fresh[i] = 0;
      if (n == 0) begin
        fresh[0] = 64'sd1 <<< 24;
      end else if (n == 1) begin
        fresh[0] = sh;
        fresh[1] = sc;
      end else begin
        a = frac_q24(2 * n - 1, n);
        b = frac_q24(n - 1, n);
        for (int l = 0; l < n; l++) begin
          c = frac_q24(l + 1, 2 * l + 3);
          d = (l > 0) ? frac_q24(l, 2 * l - 1) : 0;
          inner = mulq(sh, entry(prev, l, n)) + mulq(c, mulq(sc, entry(prev, l + 1, n)))
                  + mulq(d, mulq(sc, entry(prev, l - 1, n)));
          fresh[l] = clamp32(rnd24(a * inner) - rnd24(b * entry(prev2, l, n - 1)));
        end
        fresh[n] = mulq(sc, prev[n - 1]);
      end
      for (int l = 0; l <= n; l++) begin
        it.coeff = fresh[l][31:0];
        it.degree = n[3:0];
        it.term_index = l[3:0];
        it.last = (n == rows - 1 && l == n);
        coeff_q.push_back(it);
      end
      prev2 = prev;
      prev = fresh;
    end
  endtask

  assign pending = coeff_q.size();

  // watch the three channels
  always @(posedge clk) begin
    coeff_item_t exp_item;
    if (rst) begin
      row_count <= 4'd10;
      fail_count <= 0;
      coeffs_seen <= 0;
      coeff_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) row_count <= cfg_data;
      if (s_tvalid && s_tready) expand_request(s_tdata);
      if (m_tvalid && m_tready) begin
        coeffs_seen <= coeffs_seen + 1;
        if (coeff_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected item: coeff %h deg %0d idx %0d last %b",
                     m_tdata[31:0], m_tdata[35:32], m_tdata[39:36], m_tlast);
          fail_count <= fail_count + 1;
        end else begin
          exp_item = coeff_q.pop_front();
          if (m_tdata[31:0] !== exp_item.coeff || m_tdata[35:32] !== exp_item.degree ||
              m_tdata[39:36] !== exp_item.term_index || m_tlast !== exp_item.last) begin
            if (fail_count < 10)
              $display("mismatch: exp coeff %h deg %0d idx %0d last %b, got %h %0d %0d %b",
                       exp_item.coeff, exp_item.degree, exp_item.term_index, exp_item.last,
                       m_tdata[31:0], m_tdata[35:32], m_tdata[39:36], m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_affine_legendre_expansion.sv =====
`timescale 1ns / 1ps

module tb_affine_legendre_expansion
  import ale_pkg::*;
;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  int fail_count, pending, coeffs_seen;
  int sent = 0;
  bit hold_off = 1'b0;

  always #1 clk = ~clk;

  affine_legendre_expansion dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ale_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .coeffs_seen(coeffs_seen)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // mixes corners and small/unit values so the recursion stays in range often
  function automatic logic [31:0] pick_q24();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return ONE_Q24;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      g = ($urandom_range(0, 4) == 0) ? gap_len() : 0;
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // valid stays up after an accept; the next call or the caller drops it
  task automatic send_request(input logic [31:0] sh, input logic [31:0] sc);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {sc, sh};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic write_rows(input logic [3:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [3:0] row_set[8];
    row_set = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd2, 4'd7, 4'd11, 4'd5};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: reset setting of ten rows, extremes and plain cases
    send_request(32'h0000_0000, ONE_Q24);
    send_request(ONE_Q24, 32'h0000_0000);
    send_request(32'h0080_0000, 32'h0080_0000);
    send_request(32'h7fff_ffff, 32'h7fff_ffff);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'hffff_ffff, 32'h0000_0001);
    send_request(32'hff00_0000, 32'hff00_0000);
    send_request(32'h5555_5555, 32'haaaa_aaaa);
    hold_off = 1'b1;
    send_request(32'h0040_0000, 32'h00c0_0000);
    send_request(32'h0123_4567, 32'hfedc_ba98);
    send_request(32'h0200_0000, 32'h0100_0000);
    foreach (row_set[i]) begin
      write_rows(row_set[i]);
      // zero rows yields nothing; still feed a few requests
      repeat (row_set[i] == 0 ? 6 : 18) send_request(pick_q24(), pick_q24());
    end
    write_rows(4'd10);
    while (sent < 360) begin
      if (sent % 60 == 0) write_rows(4'($urandom_range(0, 15)));
      send_request(pick_q24(), pick_q24());
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("%0d requests sent, %0d coefficients checked, row counts 0..15 and corners",
             sent, coeffs_seen);
    if (fail_count == 0) begin
      $display("tb_affine_legendre_expansion: done, clean");
    end else begin
      $display("tb_affine_legendre_expansion: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_affine_legendre_expansion: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ale_pkg.sv
rtl/ale_cell.sv
rtl/ale_mul.sv
rtl/affine_legendre_expansion.sv
tb/ale_checker.sv
tb/tb_affine_legendre_expansion.sv
